// ----- design/psd_pkg.sv -----
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types, constants and helpers of the purchase set dissimilarity unit.
// ----------------------------------------------------------------------------
package psd_pkg;

    localparam int unsigned CUST_W  = 6;
    localparam int unsigned ROW_W   = 64;
    localparam int unsigned CNT_W   = 7;
    localparam int unsigned QDEPTH  = 2;
    localparam int unsigned QPTR_W  = 1;
    localparam int unsigned RECIP_W = 25;

    localparam logic [16:0] ONE_FIXED = 17'd65536;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [CUST_W-1:0] customer;
        logic [ROW_W-1:0]  bits;
    } t_item;

    typedef struct packed {
        logic             vld;
        logic [CNT_W-1:0] inter;
        logic [CNT_W-1:0] own;
        logic             empty;
        logic [3:0]       tgt;
        logic             last;
    } t_div_in;

    typedef struct packed {
        logic        vld;
        logic [3:0]  tgt;
        logic [16:0] dis;
        logic        empty;
        logic        last;
    } t_result;

    function automatic logic [CNT_W-1:0] pop64(input logic [ROW_W-1:0] v);
        logic [CNT_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < ROW_W; i++) begin
            sum = sum + CNT_W'(v[i]);
        end
        return sum;
    endfunction

endpackage

// ----- design/psd_queue.sv -----
// ----------------------------------------------------------------------------
// psd_queue
// Two-entry first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module psd_queue
    import psd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_head,
    output logic  o_empty,
    output logic  o_full
);

    t_item                 r_buf [QDEPTH];
    logic [QPTR_W-1:0]     r_wr_ptr;
    logic [QPTR_W-1:0]     r_rd_ptr;
    logic [QPTR_W:0]       r_count;

    assign o_head  = r_buf[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (QPTR_W+1)'(QDEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- design/psd_front.sv -----
// ----------------------------------------------------------------------------
// psd_front
// Accepts transactions, drops out-of-range customers and masks product bits.
// ----------------------------------------------------------------------------
module psd_front
    import psd_pkg::*;
#(
    parameter int CUSTOMERS = 16,
    parameter int PRODUCTS  = 64
) (
    input  logic        start,
    input  logic        i_kind,
    input  logic [3:0]  i_customer,
    input  logic [63:0] i_purchase_bits,
    input  logic        i_q_full,
    output logic        busy,
    output logic        o_push,
    output t_item       o_item
);

    localparam logic [ROW_W-1:0] PMASK = (ROW_W'(1) << PRODUCTS) - ROW_W'(1);

    logic accept;
    logic in_range;

    assign busy     = i_q_full;
    assign accept   = start && !i_q_full;
    assign in_range = (32'(i_customer) < CUSTOMERS);
    assign o_push   = accept && in_range;

    always_comb begin
        o_item.kind     = i_kind;
        o_item.customer = CUST_W'(i_customer);
        o_item.bits     = (i_kind == KIND_LOAD) ? (i_purchase_bits & PMASK) : '0;
    end

endmodule

// ----- design/psd_div.sv -----
// ----------------------------------------------------------------------------
// psd_div
// Three-stage divider: 65536 minus overlap times 65536 over own count by reciprocal table.
// ----------------------------------------------------------------------------
module psd_div
    import psd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_div_in i_op,
    output t_result o_res
);

    logic [RECIP_W-1:0] recip_tab [0:ROW_W];

    assign recip_tab[0] = '0;
    for (genvar g = 1; g <= ROW_W; g++) begin : g_recip
        localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << 24) / g);
        assign recip_tab[g] = RECIP;
    end

    t_div_in     r_s1;
    logic [31:0] r_prod;
    t_div_in     r_s2;
    logic [16:0] r_q0;
    logic [23:0] r_mul;
    logic [16:0] q0;
    logic [23:0] rem;
    logic [16:0] quot;
    t_result     n_res;
    t_result     r_res;

    assign q0   = r_prod[24:8];
    assign rem  = 24'({r_s2.inter, 16'h0}) - r_mul;
    assign quot = r_q0 + 17'(rem >= 24'(r_s2.own));

    always_comb begin
        n_res.vld   = r_s2.vld;
        n_res.tgt   = r_s2.tgt;
        n_res.empty = r_s2.empty;
        n_res.last  = r_s2.last;
        n_res.dis   = r_s2.empty ? 17'd0 : (ONE_FIXED - quot);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 32'(i_op.inter) * 32'(recip_tab[i_op.own]);
        r_q0   <= q0;
        r_mul  <= 24'(q0) * 24'(r_s1.own);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_res <= '0;
        end else begin
            r_s1  <= i_op;
            r_s2  <= r_s1;
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// ----- design/psd_back.sv -----
// ----------------------------------------------------------------------------
// psd_back
// Row store and query sequencer: loads rows, reads the queried row, then
// streams one compared row per cycle into the overlap count and divider.
// ----------------------------------------------------------------------------
module psd_back
    import psd_pkg::*;
#(
    parameter int CUSTOMERS = 16,
    parameter int PRODUCTS  = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [4:0] i_active,
    input  t_item      i_head,
    input  logic       i_q_empty,
    output logic       o_pop,
    output t_div_in    o_op
);

    localparam int AW = $clog2(CUSTOMERS);
    localparam int JW = $clog2(CUSTOMERS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ROW  = 4'b0010,
        S_OWN  = 4'b0100,
        S_RUN  = 4'b1000
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic [PRODUCTS-1:0]   r_mem [CUSTOMERS];
    logic [CUSTOMERS-1:0]  r_row_vld;
    logic [PRODUCTS-1:0]   r_rd_data;
    logic                  r_rd_vld;
    logic [AW-1:0]         r_cust;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [ROW_W-1:0]      rd_row;
    logic [ROW_W-1:0]      r_row_i;
    logic [CNT_W-1:0]      r_own;
    logic [CNT_W-1:0]      own;
    logic [JW-1:0]         r_j;
    logic [JW-1:0]         r_cnt;
    logic [JW-1:0]         cnt;
    logic [7:0]            act8;
    logic                  issue_last;
    logic                  r_a_vld;
    logic [3:0]            r_a_tgt;
    logic                  r_a_last;
    t_div_in               r_b;

    assign o_pop   = (r_state == S_IDLE) && !i_q_empty;
    assign wr_en   = o_pop && (i_head.kind == KIND_LOAD);
    assign rd_addr = (r_state == S_ROW) ? r_cust : r_j[AW-1:0];
    assign rd_row  = r_rd_vld ? ROW_W'(r_rd_data) : '0;
    assign own     = pop64(rd_row);
    assign act8    = 8'(i_active);
    assign cnt     = (act8 > 8'(CUSTOMERS)) ? JW'(CUSTOMERS) : JW'(act8);
    assign issue_last = (r_j == JW'(r_cnt - 1'b1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_pop && (i_head.kind == KIND_QUERY)) begin
                    n_state = S_ROW;
                end
            end
            S_ROW: begin
                n_state = S_OWN;
            end
            S_OWN: begin
                n_state = (cnt == '0) ? S_IDLE : S_RUN;
            end
            S_RUN: begin
                if (issue_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[i_head.customer[AW-1:0]] <= PRODUCTS'(i_head.bits);
        end
        r_rd_data <= r_mem[rd_addr];
        r_rd_vld  <= r_row_vld[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_row_vld <= '0;
            r_a_vld   <= 1'b0;
            r_b       <= '0;
        end else begin
            r_state <= n_state;
            if (wr_en) begin
                r_row_vld[i_head.customer[AW-1:0]] <= 1'b1;
            end
            r_a_vld   <= (r_state == S_RUN);
            r_b.vld   <= r_a_vld;
            r_b.inter <= pop64(rd_row & r_row_i);
            r_b.own   <= r_own;
            r_b.empty <= (r_own == '0);
            r_b.tgt   <= r_a_tgt;
            r_b.last  <= r_a_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cust <= i_head.customer[AW-1:0];
        end
        if (r_state == S_OWN) begin
            r_row_i <= rd_row;
            r_own   <= own;
            r_cnt   <= cnt;
            r_j     <= '0;
        end else if (r_state == S_RUN) begin
            r_j <= r_j + 1'b1;
        end
        r_a_tgt    <= 4'(r_j);
        r_a_last   <= issue_last;
    end

    assign o_op = r_b;

endmodule

// ----- design/purchase_set_dissimilarity_unit.sv -----
// ----------------------------------------------------------------------------
// purchase_set_dissimilarity_unit
// Per-customer purchase rows with queries that report, for each active
// customer, the share of the queried customer's purchases not shared.
// ----------------------------------------------------------------------------
// A load transaction is written to the row store as it leaves the queue; a
// query reads the queried row and then one compared row per cycle, since the
// row store has a single read port. Its results pass the row read register,
// the overlap count register and the divider stages. Results come one per
// cycle and cannot be held off, so the receiver must take every strobe. The
// front end accepts while the two-entry queue has room, so up to two
// transactions can wait behind a running query.
module purchase_set_dissimilarity_unit
    import psd_pkg::*;
#(
    parameter int CUSTOMERS = 16,
    parameter int PRODUCTS  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [3:0]  i_customer,
    input  logic [63:0] i_purchase_bits,
    output logic        o_strobe,
    output logic [3:0]  o_target_customer,
    output logic [16:0] o_dissimilarity,
    output logic        o_empty_row,
    output logic        o_last
);

    logic [4:0] r_active;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_empty;
    t_item      item;
    t_item      head;
    t_div_in    div_op;
    t_result    res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 5'd16;
        end else if (i_cfg_we) begin
            r_active <= i_cfg_wdata;
        end
    end

    psd_front #(
        .CUSTOMERS(CUSTOMERS),
        .PRODUCTS (PRODUCTS)
    ) u_front (
        .start          (start),
        .i_kind         (i_kind),
        .i_customer     (i_customer),
        .i_purchase_bits(i_purchase_bits),
        .i_q_full       (q_full),
        .busy           (busy),
        .o_push         (push),
        .o_item         (item)
    );

    psd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_item (item),
        .i_pop  (pop),
        .o_head (head),
        .o_empty(q_empty),
        .o_full (q_full)
    );

    psd_back #(
        .CUSTOMERS(CUSTOMERS),
        .PRODUCTS (PRODUCTS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_active (r_active),
        .i_head   (head),
        .i_q_empty(q_empty),
        .o_pop    (pop),
        .o_op     (div_op)
    );

    psd_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_op   (div_op),
        .o_res  (res)
    );

    assign o_strobe          = res.vld;
    assign o_target_customer = res.tgt;
    assign o_dissimilarity   = res.dis;
    assign o_empty_row       = res.empty;
    assign o_last            = res.last;

endmodule

// ----- tb/sv/purchase_set_dissimilarity_checker.sv -----
// ----------------------------------------------------------------------------
// purchase_set_dissimilarity_checker
// Watches the load, query, configuration and result channels of the purchase
// set dissimilarity unit. It keeps its own copy of the purchase rows and the
// active customer count, predicts every result of each accepted query and
// compares the results in order, field by field.
// ----------------------------------------------------------------------------
module purchase_set_dissimilarity_checker
    import psd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        start,
    input  logic        busy,
    input  logic        i_kind,
    input  logic [3:0]  i_customer,
    input  logic [63:0] i_purchase_bits,
    input  logic        i_strobe,
    input  logic [3:0]  i_target_customer,
    input  logic [16:0] i_dissimilarity,
    input  logic        i_empty_row,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0]  target;
        logic [16:0] dis;
        logic        empty;
        logic        last;
    } t_score;

    logic [63:0] purchase_rows [16];
    logic [4:0]  active_cfg;
    t_score      due_scores [$];

    function automatic void predict_scores(input logic [3:0] cust);
        int unsigned own;
        int unsigned overlap;
        int unsigned span;
        t_score      s;
        own  = $countones(purchase_rows[cust]);
        span = (active_cfg > 5'd16) ? 16 : int'(active_cfg);
        for (int j = 0; j < span; j++) begin
            s.target = 4'(j);
            if (own == 0) begin
                s.dis   = '0;
                s.empty = 1'b1;
            end else begin
                overlap = $countones(purchase_rows[cust] & purchase_rows[j]);
                s.dis   = 17'(32'(ONE_FIXED) - (overlap * 32'(ONE_FIXED)) / own);
                s.empty = 1'b0;
            end
            s.last = (j == span - 1);
            due_scores.insert(due_scores.size(), s);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_score want;
        int     errs;
        errs = 0;
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) begin
                purchase_rows[k] = '0;
            end
            active_cfg = 5'd16;
            due_scores.delete();
        end else begin
            if (i_strobe) begin
                if (due_scores.size() == 0) begin
                    $error("unexpected result transaction: target_customer %0d",
                           i_target_customer);
                    errs++;
                end else begin
                    want = due_scores.pop_front();
                    if (i_target_customer !== want.target) begin
                        $error("target_customer mismatch: expected %0d, actual %0d",
                               want.target, i_target_customer);
                        errs++;
                    end
                    if (i_dissimilarity !== want.dis) begin
                        $error("dissimilarity mismatch: expected %0d, actual %0d",
                               want.dis, i_dissimilarity);
                        errs++;
                    end
                    if (i_empty_row !== want.empty) begin
                        $error("empty_row mismatch: expected %0d, actual %0d",
                               want.empty, i_empty_row);
                        errs++;
                    end
                    if (i_last !== want.last) begin
                        $error("last mismatch: expected %0d, actual %0d",
                               want.last, i_last);
                        errs++;
                    end
                end
            end
            if (i_cfg_we) begin
                active_cfg = i_cfg_wdata;
            end
            if (start && !busy) begin
                if (i_kind == KIND_LOAD) begin
                    purchase_rows[i_customer] = i_purchase_bits;
                end else begin
                    predict_scores(i_customer);
                end
            end
        end
        o_fail_count <= o_fail_count + errs;
        o_pending    <= due_scores.size();
    end

endmodule

// ----- tb/sv/purchase_set_dissimilarity_unit_tb.sv -----
// ----------------------------------------------------------------------------
// purchase_set_dissimilarity_unit_tb
// Drives load and query transactions into the purchase set dissimilarity unit
// under several active customer counts and sender idle rates, and lets the
// checker module predict and compare every result. A short directed part
// covers full, empty and single-bit rows, empty queried rows and the count
// extremes; a random part follows.
// ----------------------------------------------------------------------------
module purchase_set_dissimilarity_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psd_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [4:0]  i_cfg_wdata;
    logic        start;
    logic        busy;
    logic        i_kind;
    logic [3:0]  i_customer;
    logic [63:0] i_purchase_bits;
    logic        o_strobe;
    logic [3:0]  o_target_customer;
    logic [16:0] o_dissimilarity;
    logic        o_empty_row;
    logic        o_last;
    int          fail_count;
    int          pending;
    int          idle_pct;

    purchase_set_dissimilarity_unit uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .start             (start),
        .busy              (busy),
        .i_kind            (i_kind),
        .i_customer        (i_customer),
        .i_purchase_bits   (i_purchase_bits),
        .o_strobe          (o_strobe),
        .o_target_customer (o_target_customer),
        .o_dissimilarity   (o_dissimilarity),
        .o_empty_row       (o_empty_row),
        .o_last            (o_last)
    );

    purchase_set_dissimilarity_checker checker_i (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .start             (start),
        .busy              (busy),
        .i_kind            (i_kind),
        .i_customer        (i_customer),
        .i_purchase_bits   (i_purchase_bits),
        .i_strobe          (o_strobe),
        .i_target_customer (o_target_customer),
        .i_dissimilarity   (o_dissimilarity),
        .i_empty_row       (o_empty_row),
        .i_last            (o_last),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("purchase_set_dissimilarity_unit verification failed");
        $finish;
    end

    function automatic logic [63:0] random_row();
        logic [63:0] r;
        int          n;
        r = '0;
        case ($urandom_range(0, 5))
            0: r = '0;
            1: r = '1;
            2: begin
                n = $urandom_range(1, 6);
                repeat (n) r[$urandom_range(0, 63)] = 1'b1;
            end
            3: r = {$urandom, $urandom};
            4: begin
                r = '1;
                n = $urandom_range(1, 6);
                repeat (n) r[$urandom_range(0, 63)] = 1'b0;
            end
            default: r = {$urandom, $urandom} & {$urandom, $urandom};
        endcase
        return r;
    endfunction

    function automatic logic [4:0] random_span();
        case ($urandom_range(0, 7))
            0: return 5'd1;
            1: return 5'd16;
            2: return 5'($urandom_range(17, 31));
            3: return 5'd0;
            default: return 5'($urandom_range(2, 15));
        endcase
    endfunction

    task automatic issue(input logic kind, input logic [3:0] cust, input logic [63:0] bits);
        logic free;
        start           <= 1'b1;
        i_kind          <= kind;
        i_customer      <= cust;
        i_purchase_bits <= bits;
        do begin
            @(negedge i_clk);
            free = !busy;
            @(posedge i_clk);
        end while (!free);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_span(input logic [4:0] value);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= '0;
        start           <= 1'b0;
        i_kind          <= KIND_LOAD;
        i_customer      <= '0;
        i_purchase_bits <= '0;
        idle_pct = 20;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        issue(KIND_QUERY, 4'd0, '1);
        issue(KIND_LOAD, 4'd0, '1);
        issue(KIND_LOAD, 4'd1, '0);
        issue(KIND_LOAD, 4'd2, 64'h0000_0000_0000_0001);
        issue(KIND_LOAD, 4'd3, 64'h8000_0000_0000_0000);
        issue(KIND_LOAD, 4'd4, 64'hAAAA_AAAA_AAAA_AAAA);
        issue(KIND_LOAD, 4'd5, 64'h5555_5555_5555_5555);
        issue(KIND_LOAD, 4'd6, 64'h0000_0000_0000_0007);
        issue(KIND_LOAD, 4'd7, 64'h0000_0000_0000_0003);
        issue(KIND_LOAD, 4'd15, '1);
        issue(KIND_QUERY, 4'd0, '0);
        issue(KIND_QUERY, 4'd1, '0);
        issue(KIND_QUERY, 4'd2, '0);
        issue(KIND_QUERY, 4'd4, '0);
        issue(KIND_QUERY, 4'd6, '0);
        issue(KIND_QUERY, 4'd15, '1);
        write_span(5'd0);
        issue(KIND_QUERY, 4'd0, '0);
        write_span(5'd31);
        issue(KIND_QUERY, 4'd4, '0);
        write_span(5'd1);
        issue(KIND_QUERY, 4'd6, '0);
        write_span(5'd17);
        issue(KIND_QUERY, 4'd2, '0);

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 20 : (phase == 1) ? 73 : 0;
            for (int seg = 0; seg < 4; seg++) begin
                write_span(random_span());
                for (int k = 0; k < 18; k++) begin
                    if ($urandom_range(0, 1) == 1) begin
                        issue(KIND_QUERY, 4'($urandom_range(0, 15)), {$urandom, $urandom});
                    end else begin
                        issue(KIND_LOAD, 4'($urandom_range(0, 15)), random_row());
                    end
                end
            end
        end

        settle();
        if (fail_count == 0) begin
            $display("purchase_set_dissimilarity_unit verification clean");
        end else begin
            $display("purchase_set_dissimilarity_unit verification failed");
        end
        $finish;
    end

endmodule
